/* hdl/npe_pkg.sv */
// Shared types and sizing for the next-permutation engine.
// Used by npe_ctrl, npe_dpath and next_permutation_engine; depends on nothing.
package npe_pkg;

	localparam int MAX_LEN    = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int IDX_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W      = $clog2(MAX_LEN + 1);

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] element;
		logic                         final_item;
	} in_beat_t;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] out_element;
		logic                         out_final;
		logic                         wrapped;
		logic                         overflowed;
	} out_beat_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;        // store an accepted beat
		logic dec;         // step the scan index left
		logic latch_prev;  // keep the right neighbor of the next read
		logic set_pivot;   // capture pivot index and value
		logic find_start;  // restart the scan at the rightmost element
		logic set_wrap;    // no pivot: emit ascending
		logic set_j;       // capture swap partner index
		logic emit_start;  // clear the emit counter
		logic emit_rd;     // read one output element
		logic emit_adv;    // advance the emit counter
		logic finish;      // sequence done, clear count and flags
	} npe_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic first_elem;  // store empty: an arriving final beat makes a single element
		logic scan_lt;     // left element smaller than its right neighbor
		logic idx_zero;    // scan index at the leftmost element
		logic find_hit;    // swap partner found
		logic emit_last;   // current output beat is the last
	} npe_stat_t;

endpackage

/* hdl/next_permutation_engine.sv */
// Top level of the next-permutation engine: controller plus datapath.
// Depends on npe_pkg, npe_ctrl and npe_dpath.
//
// Usage:
//   Input channel: drive item and raise start; a beat is taken at each rising
//   edge with start high and busy low. Beats without final_item only store
//   the element (one per cycle, busy stays low). Up to MAX_LEN elements are
//   kept; later ones are dropped and overflowed is reported on the output.
//   The beat with final_item set ends the sequence (it is stored or dropped
//   like any other) and busy rises for the whole permutation pass.
//   Result channel: one beat per stored element, left to right, each present
//   for exactly one cycle with strobe high. out_final marks the last beat;
//   wrapped marks a sequence that was already greatest and is returned in
//   ascending order. The receiver cannot stall: take every strobed beat.
// The pivot scan reads the elements right to left through the single
//   registered read port of the element memory; the partner search then
//   walks from the rightmost element toward the pivot; emission reads one
//   element per result beat. busy drops in the cycle after the last result
//   beat.
// Reset: arst_n clears the controller, the element count and the flags;
//   the element memory holds no reset value and needs none.
module next_permutation_engine import npe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_beat_t  item,
	output logic      strobe,
	output out_beat_t result
);

	npe_cmd_t  cmd;
	npe_stat_t stat;

	// Sequence the load, scan, search and emit phases.
	npe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_item (item.final_item),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.strobe     (strobe)
	);

	// Hold the elements and build each output beat.
	npe_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	// A result beat only appears during a permutation pass.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result beat outside a pass");

	// The last result beat returns the block to loading.
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.out_final) |=> !busy)
		else $error("block still busy after the last beat");

	// A non-final beat never starts a pass.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.final_item) |=> (!busy && !strobe))
		else $error("pass started without a final beat");

	// Two result beats never follow back to back.
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result beats too close");

endmodule

/* hdl/npe_dpath.sv */
// Datapath of the next-permutation engine: element memory, scan registers,
// output address generation. Depends on npe_pkg.
module npe_dpath import npe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  item,
	input  npe_cmd_t  cmd,
	output npe_stat_t stat,
	output out_beat_t result
);

	logic signed [ELEM_WIDTH-1:0] mem [MAX_LEN];
	logic signed [ELEM_WIDTH-1:0] rd_q, prev_q, pval_q;
	logic [CNT_W-1:0] cnt_q, n_q;
	logic [IDX_W-1:0] idx_q, pivot_q, j_q, k_q;
	logic             ovf_q, wrap_q;
	logic             sub_s1, last_s1;

	logic [CNT_W-1:0] new_n;
	logic             has_room;
	logic [IDX_W-1:0] emit_addr, rd_addr;
	logic             emit_sub;

	assign has_room = (cnt_q < CNT_W'(MAX_LEN));
	assign new_n    = has_room ? (cnt_q + CNT_W'(1)) : cnt_q;

	always_comb begin
		if (wrap_q) begin
			emit_addr = IDX_W'(n_q - CNT_W'(1) - CNT_W'(k_q));
		end else if (k_q < pivot_q) begin
			emit_addr = k_q;
		end else if (k_q == pivot_q) begin
			emit_addr = j_q;
		end else begin
			emit_addr = IDX_W'({1'b0, n_q} + (CNT_W+1)'(pivot_q) - (CNT_W+1)'(k_q));
		end
	end

	// Reversed suffix: the slot of the swap partner now holds the pivot value.
	assign emit_sub = !wrap_q && (k_q > pivot_q) && (emit_addr == j_q);
	assign rd_addr  = cmd.emit_rd ? emit_addr : idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			mem[IDX_W'(cnt_q)] <= item.element;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_prev) begin
			prev_q <= rd_q;
		end
		if (cmd.set_pivot) begin
			pval_q <= rd_q;
		end
		if (cmd.emit_rd) begin
			sub_s1  <= emit_sub;
			last_s1 <= (CNT_W'(k_q) + CNT_W'(1) == n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			n_q     <= '0;
			ovf_q   <= 1'b0;
			wrap_q  <= 1'b0;
			idx_q   <= '0;
			pivot_q <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= new_n;
				if (!has_room) begin
					ovf_q <= 1'b1;
				end
				if (item.final_item) begin
					n_q   <= new_n;
					idx_q <= IDX_W'(new_n - CNT_W'(1));
				end
			end
			if (cmd.dec) begin
				idx_q <= idx_q - IDX_W'(1);
			end
			if (cmd.set_pivot) begin
				pivot_q <= idx_q;
			end
			if (cmd.find_start) begin
				idx_q <= IDX_W'(n_q - CNT_W'(1));
			end
			if (cmd.set_wrap) begin
				wrap_q <= 1'b1;
			end
			if (cmd.set_j) begin
				j_q <= idx_q;
			end
			if (cmd.emit_start) begin
				k_q <= '0;
			end else if (cmd.emit_adv) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (cmd.finish) begin
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
				wrap_q <= 1'b0;
			end
		end
	end

	assign stat.first_elem = (cnt_q == '0);
	assign stat.scan_lt    = (rd_q < prev_q);
	assign stat.idx_zero   = (idx_q == '0);
	assign stat.find_hit   = (rd_q > pval_q) || (idx_q == pivot_q + IDX_W'(1));
	assign stat.emit_last  = last_s1;

	assign result.out_element = sub_s1 ? pval_q : rd_q;
	assign result.out_final   = last_s1;
	assign result.wrapped     = wrap_q;
	assign result.overflowed  = ovf_q;

endmodule

/* hdl/npe_ctrl.sv */
// Controller of the next-permutation engine: load, pivot scan, partner
// search and emission sequencing. Depends on npe_pkg.
module npe_ctrl import npe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      final_item,
	input  npe_stat_t stat,
	output npe_cmd_t  cmd,
	output logic      busy,
	output logic      strobe
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN_A,
		ST_SCAN_B,
		ST_SCAN_C,
		ST_FIND_B,
		ST_FIND_C,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_LOAD: begin
				if (start) begin
					cmd.load = 1'b1;
					if (final_item) begin
						if (stat.first_elem) begin
							cmd.set_wrap   = 1'b1;
							cmd.emit_start = 1'b1;
							state_d        = ST_EMIT_RD;
						end else begin
							state_d = ST_SCAN_A;
						end
					end
				end
			end
			ST_SCAN_A: begin
				cmd.dec = 1'b1;
				state_d = ST_SCAN_B;
			end
			ST_SCAN_B: begin
				cmd.latch_prev = 1'b1;
				state_d        = ST_SCAN_C;
			end
			ST_SCAN_C: begin
				if (stat.scan_lt) begin
					cmd.set_pivot  = 1'b1;
					cmd.find_start = 1'b1;
					state_d        = ST_FIND_B;
				end else if (stat.idx_zero) begin
					cmd.set_wrap   = 1'b1;
					cmd.emit_start = 1'b1;
					state_d        = ST_EMIT_RD;
				end else begin
					cmd.dec = 1'b1;
					state_d = ST_SCAN_B;
				end
			end
			ST_FIND_B: begin
				state_d = ST_FIND_C;
			end
			ST_FIND_C: begin
				if (stat.find_hit) begin
					cmd.set_j      = 1'b1;
					cmd.emit_start = 1'b1;
					state_d        = ST_EMIT_RD;
				end else begin
					cmd.dec = 1'b1;
					state_d = ST_FIND_B;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (stat.emit_last) begin
					cmd.finish = 1'b1;
					state_d    = ST_LOAD;
				end else begin
					cmd.emit_adv = 1'b1;
					state_d      = ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy   = (state_q != ST_LOAD);
	assign strobe = (state_q == ST_EMIT_OUT);

endmodule
